// ===== rtl/tnrf_pkg.sv =====
// ============================================================================
// tnrf_pkg : shared types, constants and tables of the tanh recursive filter
// Holds field widths, register indexes, controller commands and the tanh
// segment table with its lookup and tap-reduction helpers.
// ============================================================================
package tnrf_pkg;

  // Default length of the delay line
  localparam int unsigned MaxDelayDefault = 1024;

  // Field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned TapsW   = 10;
  localparam int unsigned CfgIdxW = 3;

  // Datapath widths
  localparam int unsigned AccW     = 52;  // exact sum at scale 2^-43
  localparam int unsigned MulW     = 25;  // shared multiplier operand
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned MagW     = 47;  // clamped magnitude, 0 .. 2^46
  localparam int unsigned SegShift = 41;  // segment width of the tanh table
  localparam int unsigned IdxW     = MagW - SegShift;
  localparam int unsigned FracLoW  = 20;
  localparam int unsigned FracHiW  = SegShift - FracLoW;
  localparam int unsigned TabW     = 23;  // table entries stay below 2^23
  localparam int unsigned DiffW    = 22;
  localparam int unsigned IpW      = 44;  // one partial interpolation product

  // Number of segments; the last entry holds the saturated value
  localparam int unsigned TabLast = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A     = 3'd0,
    REG_COEF_B     = 3'd1,
    REG_COEF_D     = 3'd2,
    REG_OFFSET_C   = 3'd3,
    REG_DELAY_TAPS = 3'd4
  } cfg_reg_e;

  // Delay line read address select
  typedef enum logic [1:0] {
    RD_LAG,
    RD_P1,
    RD_P2
  } rd_sel_e;

  // Shared multiplier operand select
  typedef enum logic [2:0] {
    MUL_SQ,
    MUL_A,
    MUL_B,
    MUL_D,
    MUL_FH,
    MUL_FL
  } mul_sel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD
  } acc_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     cap_in;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     ld_yl;
    logic     ld_y1;
    logic     ld_y2;
    logic     ld_ysq;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     ld_seg;
    logic     ld_ip;
    logic     ld_y;
    logic     commit;
  } dp_cmd_t;

  // tanh at arguments 0, 0.25, .. 8, Q1.23
  function automatic logic [TabW-1:0] tanh_tab(input logic [IdxW-1:0] idx);
    logic [TabW-1:0] v;
    case (idx)
      6'd0:    v = 23'd0;
      6'd1:    v = 23'd2054527;
      6'd2:    v = 23'd3876520;
      6'd3:    v = 23'd5328016;
      6'd4:    v = 23'd6388715;
      6'd5:    v = 23'd7115919;
      6'd6:    v = 23'd7592934;
      6'd7:    v = 23'd7896830;
      6'd8:    v = 23'd8086849;
      6'd9:    v = 23'd8204278;
      6'd10:   v = 23'd8276321;
      6'd11:   v = 23'd8320322;
      6'd12:   v = 23'd8347124;
      6'd13:   v = 23'd8363422;
      6'd14:   v = 23'd8373323;
      6'd15:   v = 23'd8379334;
      6'd16:   v = 23'd8382982;
      6'd17:   v = 23'd8385195;
      6'd18:   v = 23'd8386538;
      6'd19:   v = 23'd8387352;
      6'd20:   v = 23'd8387846;
      6'd21:   v = 23'd8388146;
      6'd22:   v = 23'd8388328;
      6'd23:   v = 23'd8388438;
      6'd24:   v = 23'd8388505;
      6'd25:   v = 23'd8388545;
      6'd26:   v = 23'd8388570;
      6'd27:   v = 23'd8388585;
      6'd28:   v = 23'd8388594;
      6'd29:   v = 23'd8388600;
      6'd30:   v = 23'd8388603;
      6'd31:   v = 23'd8388605;
      default: v = 23'd8388606;
    endcase
    return v;
  endfunction

  // Reduce a tap count modulo the line depth by conditional subtraction.
  // Depth is at least four, so eight shifted subtractions cover any 10 bit value.
  function automatic logic [31:0] taps_mod(input logic [TapsW-1:0] taps,
                                           input int unsigned depth);
    logic [31:0] r;
    r = 32'(taps);
    for (int k = 7; k >= 0; k--) begin
      if ((depth << k) <= r) begin
        r = r - (depth << k);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/tnrf_ram.sv =====
// ============================================================================
// tnrf_ram : generic single-write, single-read RAM
// One write port and one read port, read data registered, no reset.
// ============================================================================
module tnrf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tnrf_ctrl.sv =====
// ============================================================================
// tnrf_ctrl : sequencer of the tanh recursive filter
// Steps each word through delay-line reads, the shared multiplier schedule,
// the tanh lookup and the write-back, and owns the output valid flag.
// ============================================================================
module tnrf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output tnrf_pkg::dp_cmd_t cmd_o
);

  import tnrf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_L,
    ST_RD_1,
    ST_RD_2,
    ST_SQ,
    ST_MA,
    ST_MB,
    ST_MD,
    ST_SEG,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_WR
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  // Decode commands from the state
  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_LAG;
    cmd.mul_sel = MUL_SQ;
    cmd.acc_op  = ACC_HOLD;
    state_d     = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd.cap_in = in_valid_i;
        if (in_valid_i) state_d = ST_RD_L;
      end
      ST_RD_L: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAG;
        cmd.acc_op = ACC_INIT;
        state_d    = ST_RD_1;
      end
      ST_RD_1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_P1;
        cmd.ld_yl  = 1'b1;
        state_d    = ST_RD_2;
      end
      ST_RD_2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_P2;
        cmd.ld_y1   = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_d     = ST_SQ;
      end
      ST_SQ: begin
        cmd.ld_y2   = 1'b1;
        cmd.ld_ysq  = 1'b1;
        cmd.mul_sel = MUL_A;
        state_d     = ST_MA;
      end
      ST_MA: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_B;
        state_d     = ST_MB;
      end
      ST_MB: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_D;
        state_d     = ST_MD;
      end
      ST_MD: begin
        cmd.acc_op = ACC_ADD;
        state_d    = ST_SEG;
      end
      ST_SEG: begin
        cmd.ld_seg = 1'b1;
        state_d    = ST_F1;
      end
      ST_F1: begin
        cmd.mul_sel = MUL_FH;
        state_d     = ST_F2;
      end
      ST_F2: begin
        cmd.ld_ip   = 1'b1;
        cmd.mul_sel = MUL_FL;
        state_d     = ST_F3;
      end
      ST_F3: begin
        cmd.ld_y = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        // hold the result until the output register is free
        cmd.commit = !out_valid_q || out_ready_i;
        if (cmd.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Load the output flag on commit, drop it once the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // A new word is never taken in the cycle after one was accepted
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Output valid rises only from a write-back
  a_valid_from_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WR))
    else $error("output valid without write-back");

  // A blocked write-back keeps its place and the pending word
  a_wr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) && out_valid_q && !out_ready_i |=>
      (state_q == ST_WR) && out_valid_q)
    else $error("write-back left while output blocked");

endmodule

// ===== rtl/tnrf_datapath.sv =====
// ============================================================================
// tnrf_datapath : arithmetic and storage of the tanh recursive filter
// Holds configuration, the delay line with its pointer and fill count, the
// shared multiplier, the wide accumulator and the tanh interpolation.
// ============================================================================
module tnrf_datapath #(
  parameter int unsigned MAX_DELAY = tnrf_pkg::MaxDelayDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tnrf_pkg::dp_cmd_t             cmd_i,
  input  logic [tnrf_pkg::SampleW-1:0]  in_sample_i,
  input  logic                          in_last_i,
  input  logic                          cfg_we_i,
  input  logic [tnrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tnrf_pkg::CoefW-1:0]    cfg_data_i,
  output logic [tnrf_pkg::SampleW-1:0]  out_sample_o,
  output logic                          out_last_o
);

  import tnrf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam logic [AW:0]   DepthX   = (AW+1)'(MAX_DELAY);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_DELAY - 1);
  localparam logic signed [AccW-1:0] ArgLimit =
    {{(AccW-MagW){1'b0}}, 1'b1, {(MagW-1){1'b0}}};

  // Configuration
  logic signed [CoefW-1:0] a_q, b_q, d_q, c_q;
  logic [AW-1:0]           lag_q;

  // Pointer and fill count
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW:0]   fill_q, fill_d;

  // Payload
  logic signed [SampleW-1:0] x_q, yl_q, y1_q, y2_q;
  logic                      last_q;
  logic [SampleW-1:0]        ysq_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      neg_q;
  logic [TabW-1:0]           base_q;
  logic [DiffW-1:0]          diff_q;
  logic [FracHiW-1:0]        fh_q;
  logic [FracLoW-1:0]        fl_q;
  logic [IpW-1:0]            ip_q;
  logic [SampleW-1:0]        r_q;
  logic                      rd_valid_q;
  logic [SampleW-1:0]        out_sample_q;
  logic                      out_last_q;

  // Combinational
  logic [AW:0]               ptr_x, lag_x;
  logic [AW-1:0]             addr_l, addr_1, addr_2, rd_addr;
  logic [SampleW-1:0]        ram_rdata;
  logic signed [SampleW-1:0] ram_y;
  logic signed [MulW-1:0]    op_a, op_b;
  logic signed [AccW-1:0]    arg_cl, mag_full;
  logic [MagW-1:0]           mag;
  logic [IdxW-1:0]           seg_idx;
  logic [63:0]               ip_total;
  logic [SampleW-1:0]        y_res;

  // Configuration writes; the tap is reduced to a line offset on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      d_q   <= '0;
      c_q   <= '0;
      lag_q <= AW'(taps_mod(TapsW'(1), MAX_DELAY));
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COEF_A:     a_q   <= cfg_data_i;
        REG_COEF_B:     b_q   <= cfg_data_i;
        REG_COEF_D:     d_q   <= cfg_data_i;
        REG_OFFSET_C:   c_q   <= cfg_data_i;
        REG_DELAY_TAPS: lag_q <= AW'(taps_mod(cfg_data_i[TapsW-1:0], MAX_DELAY));
        default: ;
      endcase
    end
  end

  // Read addresses behind the write pointer, wrapped at the line depth
  always_comb begin
    ptr_x  = {1'b0, ptr_q};
    lag_x  = {1'b0, lag_q};
    addr_1 = (ptr_q == '0) ? LastAddr : ptr_q - 1'b1;
    addr_2 = (ptr_x >= (AW+1)'(2)) ? AW'(ptr_x - (AW+1)'(2))
                                   : AW'(ptr_x + DepthX - (AW+1)'(2));
    addr_l = (ptr_x >= lag_x) ? AW'(ptr_x - lag_x) : AW'(ptr_x + DepthX - lag_x);
    case (cmd_i.rd_sel)
      RD_LAG:  rd_addr = addr_l;
      RD_P1:   rd_addr = addr_1;
      RD_P2:   rd_addr = addr_2;
      default: rd_addr = addr_l;
    endcase
  end

  // Advance pointer and fill count on write-back
  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    if (cmd_i.commit) begin
      ptr_d = (ptr_q == LastAddr) ? '0 : ptr_q + 1'b1;
      if (fill_q != DepthX) fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
    end
  end

  // Delay line; entries at or beyond the fill count read as zero
  tnrf_ram #(
    .WIDTH (SampleW),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (ptr_q),
    .wdata_i (y_res),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign ram_y = rd_valid_q ? $signed(ram_rdata) : '0;

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        op_a = MulW'(yl_q);
        op_b = MulW'(yl_q);
      end
      MUL_A: begin
        op_a = MulW'(a_q);
        op_b = MulW'(y1_q);
      end
      MUL_B: begin
        op_a = MulW'(b_q);
        op_b = MulW'(y2_q);
      end
      MUL_D: begin
        op_a = MulW'(d_q);
        op_b = $signed({1'b0, ysq_q});
      end
      MUL_FH: begin
        op_a = $signed(MulW'(diff_q));
        op_b = $signed(MulW'(fh_q));
      end
      MUL_FL: begin
        op_a = $signed(MulW'(diff_q));
        op_b = $signed(MulW'(fl_q));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Clamp the argument to plus or minus eight and split into segment and fraction
  always_comb begin
    if (acc_q > ArgLimit) begin
      arg_cl = ArgLimit;
    end else if (acc_q < -ArgLimit) begin
      arg_cl = -ArgLimit;
    end else begin
      arg_cl = acc_q;
    end
    mag_full = acc_q[AccW-1] ? -arg_cl : arg_cl;
    mag      = mag_full[MagW-1:0];
    seg_idx  = mag[MagW-1:SegShift];
  end

  // Recombine the two partial interpolation products
  assign ip_total = (64'(ip_q) << FracLoW) + 64'(prod_q[IpW-1:0]);

  // Apply the sign of the argument
  assign y_res = neg_q ? -r_q : r_q;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      x_q    <= in_sample_i;
      last_q <= in_last_i;
    end
    rd_valid_q <= ({1'b0, rd_addr} < fill_q);
    if (cmd_i.ld_yl) yl_q <= ram_y;
    if (cmd_i.ld_y1) y1_q <= ram_y;
    if (cmd_i.ld_y2) y2_q <= ram_y;
    if (cmd_i.ld_ysq) ysq_q <= prod_q[2*SampleW-2:SampleW-1];
    prod_q <= op_a * op_b;
    case (cmd_i.acc_op)
      ACC_INIT: acc_q <= (AccW'(x_q) <<< 20) - (AccW'(c_q) <<< 23);
      ACC_ADD:  acc_q <= acc_q + AccW'(prod_q);
      default:  ;
    endcase
    if (cmd_i.ld_seg) begin
      neg_q  <= acc_q[AccW-1];
      base_q <= tanh_tab(seg_idx);
      diff_q <= (seg_idx >= IdxW'(TabLast)) ? '0
              : DiffW'(tanh_tab(seg_idx + 1'b1) - tanh_tab(seg_idx));
      fh_q   <= mag[SegShift-1:FracLoW];
      fl_q   <= mag[FracLoW-1:0];
    end
    if (cmd_i.ld_ip) ip_q <= prod_q[IpW-1:0];
    if (cmd_i.ld_y) r_q <= SampleW'(base_q) + SampleW'(ip_total[63:SegShift]);
    if (cmd_i.commit) begin
      out_sample_q <= y_res;
      out_last_q   <= last_q;
    end
  end

  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

  // Pointer stays inside the line
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastAddr)
    else $error("write pointer beyond line");

  // Fill count never passes the depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthX)
    else $error("fill count beyond depth");

  // Until the first wrap the pointer tracks the fill count
  a_fill_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != DepthX) |-> (ptr_q == fill_q[AW-1:0]))
    else $error("pointer and fill count disagree");

endmodule

// ===== rtl/tanh_nonlinear_recursive_filter_core.sv =====
// ============================================================================
// tanh_nonlinear_recursive_filter_core : tanh recursive filter, top level
// Streams Q1.23 samples through y = tanh(a*y1 + b*y2 + d*yL^2 + x - C) with
// a circular delay line and a register-mapped configuration port.
// ============================================================================
// One word in flight: a new input is taken only after the last is written back,
// since the six products share one 25x25 multiplier and the three reads go
// through the single delay-line port; a blocked output stalls the write-back.
// Reset: configuration to defaults, pointer and fill count cleared; delay-line
// entries not yet written read as zero through the fill count, no clearing pass.
module tanh_nonlinear_recursive_filter_core #(
  parameter int unsigned MAX_DELAY = tnrf_pkg::MaxDelayDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // [23:0] sample_in
  input  logic                         s_axis_tlast,  // block_last
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // [23:0] sample_out
  output logic                         m_axis_tlast,  // block_end
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tnrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tnrf_pkg::CoefW-1:0]   cfg_data_i
);

  import tnrf_pkg::*;

  dp_cmd_t cmd;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  tnrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  tnrf_datapath #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_sample_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
